// ===== sv/tcf_pkg.sv =====
// tcf_pkg: shared constants, types and helpers for the triangle coverage fill block.
// Depends on nothing; imported by every module of the block.
package tcf_pkg;

  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 1024;
  localparam int COORD_W      = 10;    // pixel coordinate width on the result channel
  localparam int VTX_W        = 16;    // vertex coordinate width
  localparam int COLOUR_W     = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_V0X    = 3'd0,
    CFG_V0Y    = 3'd1,
    CFG_V1X    = 3'd2,
    CFG_V1Y    = 3'd3,
    CFG_V2X    = 3'd4,
    CFG_V2Y    = 3'd5,
    CFG_COLOUR = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [VTX_W-1:0] v0x;
    logic signed [VTX_W-1:0] v0y;
    logic signed [VTX_W-1:0] v1x;
    logic signed [VTX_W-1:0] v1y;
    logic signed [VTX_W-1:0] v2x;
    logic signed [VTX_W-1:0] v2y;
    logic [COLOUR_W-1:0]     colour;
  } tri_cfg_t;

  // One pixel to test, passed from the scan front end to the coverage back end
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } pix_t;

  // Queue status toward the front end and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [VTX_W-1:0] min3(input logic signed [VTX_W-1:0] a,
                                                   input logic signed [VTX_W-1:0] b,
                                                   input logic signed [VTX_W-1:0] c);
    logic signed [VTX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VTX_W-1:0] max3(input logic signed [VTX_W-1:0] a,
                                                   input logic signed [VTX_W-1:0] b,
                                                   input logic signed [VTX_W-1:0] c);
    logic signed [VTX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

// ===== sv/tcf_front.sv =====
// tcf_front: accepts scan transactions, latches the clipped bounding box and
// walks the raster scan, pushing one pixel per result into the queue. Uses tcf_pkg.
module tcf_front import tcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tri_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_start_scan,
  input  q_stat_t  q_stat,
  output logic     push,
  output pix_t     push_pix
);

  localparam logic signed [VTX_W:0] X_LIM = (VTX_W+1)'(IMAGE_WIDTH - 1);
  localparam logic signed [VTX_W:0] Y_LIM = (VTX_W+1)'(IMAGE_HEIGHT - 1);

  logic [COORD_W-1:0] scan_x_r, scan_x_nxt;
  logic [COORD_W-1:0] scan_y_r, scan_y_nxt;
  logic [COORD_W-1:0] box_x_min_r, box_x_min_nxt;
  logic [COORD_W-1:0] box_x_max_r, box_x_max_nxt;
  logic [COORD_W-1:0] box_y_max_r, box_y_max_nxt;
  logic               active_r, active_nxt;

  logic signed [VTX_W:0] xmin, xmax, ymin, ymax;
  logic                  box_empty, accept;
  logic [COORD_W-1:0]    cur_x, cur_y, cur_x_min, cur_x_max, cur_y_max;
  logic                  emit, last;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Bounding box, clipped to the image
  always_comb begin
    xmin = (VTX_W+1)'(min3(cfg.v0x, cfg.v1x, cfg.v2x));
    xmax = (VTX_W+1)'(max3(cfg.v0x, cfg.v1x, cfg.v2x));
    ymin = (VTX_W+1)'(min3(cfg.v0y, cfg.v1y, cfg.v2y));
    ymax = (VTX_W+1)'(max3(cfg.v0y, cfg.v1y, cfg.v2y));
    if (xmin < 0) xmin = '0;
    if (ymin < 0) ymin = '0;
    if (xmax > X_LIM) xmax = X_LIM;
    if (ymax > Y_LIM) ymax = Y_LIM;
    box_empty = (xmin > xmax) || (ymin > ymax);
  end

  always_comb begin
    if (in_start_scan) begin
      cur_x     = xmin[COORD_W-1:0];
      cur_y     = ymin[COORD_W-1:0];
      cur_x_min = xmin[COORD_W-1:0];
      cur_x_max = xmax[COORD_W-1:0];
      cur_y_max = ymax[COORD_W-1:0];
      emit      = !box_empty;
    end else begin
      cur_x     = scan_x_r;
      cur_y     = scan_y_r;
      cur_x_min = box_x_min_r;
      cur_x_max = box_x_max_r;
      cur_y_max = box_y_max_r;
      emit      = active_r;
    end
    last = (cur_x >= cur_x_max) && (cur_y >= cur_y_max);
  end

  always_comb begin
    scan_x_nxt    = scan_x_r;
    scan_y_nxt    = scan_y_r;
    box_x_min_nxt = box_x_min_r;
    box_x_max_nxt = box_x_max_r;
    box_y_max_nxt = box_y_max_r;
    active_nxt    = active_r;
    if (accept) begin
      if (in_start_scan && !box_empty) begin
        box_x_min_nxt = cur_x_min;
        box_x_max_nxt = cur_x_max;
        box_y_max_nxt = cur_y_max;
      end
      if (!emit) begin
        active_nxt = 1'b0;
      end else if (last) begin
        active_nxt = 1'b0;
      end else if (cur_x >= cur_x_max) begin
        active_nxt = 1'b1;
        scan_x_nxt = cur_x_min;
        scan_y_nxt = cur_y + 1'b1;
      end else begin
        active_nxt = 1'b1;
        scan_x_nxt = cur_x + 1'b1;
        scan_y_nxt = cur_y;
      end
    end
  end

  assign push          = accept && emit;
  assign push_pix.x    = cur_x;
  assign push_pix.y    = cur_y;
  assign push_pix.last = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_x_r    <= '0;
      scan_y_r    <= '0;
      box_x_min_r <= '0;
      box_x_max_r <= '0;
      box_y_max_r <= '0;
      active_r    <= 1'b0;
    end else begin
      scan_x_r    <= scan_x_nxt;
      scan_y_r    <= scan_y_nxt;
      box_x_min_r <= box_x_min_nxt;
      box_x_max_r <= box_x_max_nxt;
      box_y_max_r <= box_y_max_nxt;
      active_r    <= active_nxt;
    end
  end

endmodule

// ===== sv/tcf_queue.sv =====
// tcf_queue: small flop-based FIFO of pixels between the scan front end and
// the coverage back end. Uses tcf_pkg.
module tcf_queue import tcf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  pix_t    push_pix,
  input  logic    pop,
  output pix_t    head_pix,
  output q_stat_t q_stat
);

  pix_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign head_pix     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/tcf_back.sv =====
// tcf_back: coverage pipeline. Edge differences, cross-product multiplies,
// subtracts, sign tests and the output register. Uses tcf_pkg.
module tcf_back import tcf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tri_cfg_t           cfg,
  input  q_stat_t            q_stat,
  input  pix_t               head_pix,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic               out_covered,
  output logic [COLOUR_W-1:0] out_pixel_colour,
  output logic               out_last_pixel
);

  localparam int D_W = VTX_W + 1;   // edge vector
  localparam int P_W = VTX_W + 2;   // vertex minus pixel
  localparam int M_W = D_W + P_W;   // product
  localparam int C_W = M_W + 1;     // cross term
  localparam int S_W = C_W + 1;     // cx + cy

  logic advance;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  pix_t p1_r, p2_r, p3_r, p4_r;

  // stage 1
  logic signed [D_W-1:0] abx_r, aby_r, acx_r, acy_r;
  logic signed [P_W-1:0] pax_r, pay_r;
  logic signed [D_W-1:0] abx_nxt, aby_nxt, acx_nxt, acy_nxt;
  logic signed [P_W-1:0] pax_nxt, pay_nxt;
  // stage 2
  logic signed [M_W-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  // stage 3
  logic signed [C_W-1:0] cx_r, cy_r, cz_r;
  // stage 4
  logic signed [S_W-1:0] sum_r;
  logic signed [C_W-1:0] cz4_r;
  logic                  sign_ok_r, cz_pos_r, cz_neg_r;
  logic                  cz_pos, cz_neg, sign_ok, cov;
  // output
  logic [COORD_W-1:0]    ox_r, oy_r;
  logic                  ocov_r, olast_r;
  logic [COLOUR_W-1:0]   ocol_r;

  assign advance = !out_valid_r || out_ready;
  assign pop     = advance && !q_stat.empty;

  always_comb begin
    abx_nxt = D_W'(cfg.v1x) - D_W'(cfg.v0x);
    aby_nxt = D_W'(cfg.v1y) - D_W'(cfg.v0y);
    acx_nxt = D_W'(cfg.v2x) - D_W'(cfg.v0x);
    acy_nxt = D_W'(cfg.v2y) - D_W'(cfg.v0y);
    pax_nxt = P_W'(cfg.v0x) - $signed(P_W'(head_pix.x));
    pay_nxt = P_W'(cfg.v0y) - $signed(P_W'(head_pix.y));
  end

  always_comb begin
    cz_pos  = !cz_r[C_W-1] && (cz_r != '0);
    cz_neg  = cz_r[C_W-1];
    sign_ok = cz_pos ? (!cx_r[C_W-1] && !cy_r[C_W-1])
                     : (cz_neg && (cx_r <= 0) && (cy_r <= 0));
    cov     = sign_ok_r && ((cz_pos_r && (sum_r <= S_W'(cz4_r))) ||
                            (cz_neg_r && (sum_r >= S_W'(cz4_r))));
  end

  // payload: advance together, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      p1_r  <= head_pix;
      abx_r <= abx_nxt;
      aby_r <= aby_nxt;
      acx_r <= acx_nxt;
      acy_r <= acy_nxt;
      pax_r <= pax_nxt;
      pay_r <= pay_nxt;

      p2_r  <= p1_r;
      m0_r  <= M_W'(acx_r) * M_W'(pay_r);
      m1_r  <= M_W'(pax_r) * M_W'(acy_r);
      m2_r  <= M_W'(pax_r) * M_W'(aby_r);
      m3_r  <= M_W'(abx_r) * M_W'(pay_r);
      m4_r  <= M_W'(abx_r) * M_W'(acy_r);
      m5_r  <= M_W'(acx_r) * M_W'(aby_r);

      p3_r  <= p2_r;
      cx_r  <= C_W'(m0_r) - C_W'(m1_r);
      cy_r  <= C_W'(m2_r) - C_W'(m3_r);
      cz_r  <= C_W'(m4_r) - C_W'(m5_r);

      p4_r      <= p3_r;
      sum_r     <= S_W'(cx_r) + S_W'(cy_r);
      cz4_r     <= cz_r;
      sign_ok_r <= sign_ok;
      cz_pos_r  <= cz_pos;
      cz_neg_r  <= cz_neg;

      ox_r    <= p4_r.x;
      oy_r    <= p4_r.y;
      olast_r <= p4_r.last;
      ocov_r  <= cov;
      ocol_r  <= cov ? cfg.colour : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= !q_stat.empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = ox_r;
  assign out_pixel_y      = oy_r;
  assign out_covered      = ocov_r;
  assign out_pixel_colour = ocol_r;
  assign out_last_pixel   = olast_r;

endmodule

// ===== sv/triangle_coverage_fill.sv =====
// Triangle coverage fill: bounding-box raster scan with an exact integer
// inside test. Depends on tcf_pkg, tcf_front, tcf_queue and tcf_back.
// Usage:
//   Write the three vertices (signed 16-bit pixels) and the fill colour on
//   the cfg_ port (cfg_we, cfg_index, cfg_data) while the block is idle.
//   Each input transaction carries in_start_scan: 1 latches the bounding
//   box, clipped to the image, and yields the box origin; 0 yields the next
//   pixel of the scan, x fastest, then y. An empty box, or an advance while
//   idle, yields no result transaction.
//   Each result transaction gives the pixel coordinates, the covered flag,
//   the colour (zero when not covered) and last_pixel on the box's final
//   pixel, after which the scan goes idle.
// Timing: one pixel per clock sustained while out_ready stays high. After
//   its input is accepted, a result passes the queue write, which lands at
//   the accepting edge, then four arithmetic stages (differences, multiplies,
//   subtracts, sign tests) and the output register.
// Reset (synchronous, rst_n low): non-payload registers clear, scan idle, queue empty.
// Back pressure: a result held by a low out_ready stalls the pipeline; the front
//   end keeps accepting until the 4-entry queue fills, then drops in_ready.
module triangle_coverage_fill import tcf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_start_scan,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    out_pixel_x,
  output logic [COORD_W-1:0]    out_pixel_y,
  output logic                  out_covered,
  output logic [COLOUR_W-1:0]   out_pixel_colour,
  output logic                  out_last_pixel
);

  tri_cfg_t cfg_r, cfg_nxt;
  q_stat_t  q_stat;
  logic     push, pop;
  pix_t     push_pix, head_pix;

  // Register file: indexes past the colour are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_V0X:    cfg_nxt.v0x    = cfg_data[VTX_W-1:0];
        CFG_V0Y:    cfg_nxt.v0y    = cfg_data[VTX_W-1:0];
        CFG_V1X:    cfg_nxt.v1x    = cfg_data[VTX_W-1:0];
        CFG_V1Y:    cfg_nxt.v1y    = cfg_data[VTX_W-1:0];
        CFG_V2X:    cfg_nxt.v2x    = cfg_data[VTX_W-1:0];
        CFG_V2Y:    cfg_nxt.v2y    = cfg_data[VTX_W-1:0];
        CFG_COLOUR: cfg_nxt.colour = cfg_data[COLOUR_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: scan walker
  tcf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_scan (in_start_scan),
    .q_stat        (q_stat),
    .push          (push),
    .push_pix      (push_pix)
  );

  // Decoupling queue
  tcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pix (push_pix),
    .pop      (pop),
    .head_pix (head_pix),
    .q_stat   (q_stat)
  );

  // Back end: coverage pipeline and output register
  tcf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .head_pix         (head_pix),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_covered      (out_covered),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

// ===== sv/tcf_checker.sv =====
// tcf_checker: port-level assertions for triangle_coverage_fill, bound to the
// top level. Uses tcf_pkg.
module tcf_checker import tcf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_W-1:0]    out_pixel_x,
  input logic [COORD_W-1:0]    out_pixel_y,
  input logic                  out_covered,
  input logic [COLOUR_W-1:0]   out_pixel_colour,
  input logic                  out_last_pixel
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_covered) &&
      $stable(out_pixel_colour) && $stable(out_last_pixel))
    else $error("result changed while stalled");

  // Uncovered pixels carry no colour
  a_no_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_covered |-> out_pixel_colour == '0)
    else $error("colour on uncovered pixel");

  // Reset empties the result channel and opens the input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle right after reset");

  // Handshake controls and a valid result's payload are always known
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_ready, out_valid}) &&
      (!out_valid || !$isunknown({out_pixel_x, out_pixel_y, out_covered,
                                   out_pixel_colour, out_last_pixel})))
    else $error("unknown value on a handshake or result");

endmodule

bind triangle_coverage_fill tcf_checker u_tcf_checker (.*);

// ===== tb/sv/triangle_coverage_fill_test.sv =====
// Self-checking testbench for triangle_coverage_fill: directed and random triangle scans.
// Predicts each pixel transaction with its own scan and inside-test model.
// Depends on tcf_pkg and the triangle_coverage_fill RTL.
`timescale 1ns / 100ps

module triangle_coverage_fill_test;
  import tcf_pkg::*;

  // Run control
  localparam int CYCLE_LIMIT    = 300000; // hard stop, far above the slowest correct run
  localparam int DRAIN_CYCLES   = 12;     // well above the pipeline latency
  localparam int HOLD_CYCLES    = 200;    // long receiver hold-off used to fill the block
  localparam int RANDOM_PIXELS  = 440;    // random part stops after this many more pixels
  localparam int MAX_GAP        = 8;      // longest sender gap between bursts
  localparam int MAX_BURST      = 20;

  // Register index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                covered;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } pixel_result_t;

  // DUT connections, all inputs known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_start_scan = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [COORD_W-1:0]    out_pixel_x;
  logic [COORD_W-1:0]    out_pixel_y;
  logic                  out_covered;
  logic [COLOUR_W-1:0]   out_pixel_colour;
  logic                  out_last_pixel;

  // Predicted triangle setup and scan state
  logic signed [VTX_W-1:0] tri_x [3];
  logic signed [VTX_W-1:0] tri_y [3];
  logic [COLOUR_W-1:0]     fill_value;
  logic [COORD_W-1:0]      scan_x, scan_y, box_lo_x, box_hi_x, box_hi_y;
  logic                    scan_busy;

  pixel_result_t expected_pixels [$];

  // Bookkeeping
  int mismatches      = 0;
  int pixels_expected = 0;
  int pixels_checked  = 0;
  int pixels_inside   = 0;
  int box_ends        = 0;
  int requests_sent   = 0;
  int triangles_set   = 0;
  int cycle_count     = 0;

  // Sender burst control, owned by the test thread
  bit gaps_on    = 1'b0;
  int burst_left = 0;

  // Receiver hold-off requests: the test bumps hold_requests, the receiver serves them
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  logic [15:0] sink_tick = '0;

  triangle_coverage_fill dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_scan    (in_start_scan),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_covered      (out_covered),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Exact inside test: edge cross products against the pixel offset, sign folded
  // into the comparisons so no division is needed. A zero-area triangle covers nothing.
  function automatic bit pixel_inside(input logic [COORD_W-1:0] px,
                                      input logic [COORD_W-1:0] py);
    longint ax, ay, abx, aby, acx, acy, pax, pay, cx, cy, cz;
    ax  = tri_x[0];
    ay  = tri_y[0];
    abx = tri_x[1] - ax;
    aby = tri_y[1] - ay;
    acx = tri_x[2] - ax;
    acy = tri_y[2] - ay;
    pax = ax - int'(px);
    pay = ay - int'(py);
    cx  = acx * pay - pax * acy;
    cy  = pax * aby - abx * pay;
    cz  = abx * acy - acx * aby;
    if (cz == 0) return 1'b0;
    if (cz < 0) begin
      cx = -cx;
      cy = -cy;
      cz = -cz;
    end
    return (cx >= 0) && (cy >= 0) && (cx + cy <= cz);
  endfunction

  // Advance the predicted scan by one request and queue the pixel it yields, if any
  task automatic rasterize_request(input logic start);
    longint lo_x, hi_x, lo_y, hi_y;
    pixel_result_t pix;
    if (start) begin
      lo_x = tri_x[0];
      hi_x = tri_x[0];
      lo_y = tri_y[0];
      hi_y = tri_y[0];
      for (int v = 1; v < 3; v++) begin
        if (tri_x[v] < lo_x) lo_x = tri_x[v];
        if (tri_x[v] > hi_x) hi_x = tri_x[v];
        if (tri_y[v] < lo_y) lo_y = tri_y[v];
        if (tri_y[v] > hi_y) hi_y = tri_y[v];
      end
      // clip the box to the image
      if (lo_x < 0) lo_x = 0;
      if (lo_y < 0) lo_y = 0;
      if (hi_x > IMAGE_WIDTH - 1) hi_x = IMAGE_WIDTH - 1;
      if (hi_y > IMAGE_HEIGHT - 1) hi_y = IMAGE_HEIGHT - 1;
      if (lo_x > hi_x || lo_y > hi_y) begin
        scan_busy = 1'b0;  // empty box: drop to idle, emit nothing
        return;
      end
      box_lo_x  = lo_x[COORD_W-1:0];
      box_hi_x  = hi_x[COORD_W-1:0];
      box_hi_y  = hi_y[COORD_W-1:0];
      scan_x    = lo_x[COORD_W-1:0];
      scan_y    = lo_y[COORD_W-1:0];
      scan_busy = 1'b1;
    end
    if (!scan_busy) return;

    pix.x       = scan_x;
    pix.y       = scan_y;
    pix.covered = pixel_inside(scan_x, scan_y);
    pix.colour  = pix.covered ? fill_value : '0;
    pix.last    = (scan_x >= box_hi_x) && (scan_y >= box_hi_y);
    expected_pixels.push_back(pix);
    pixels_expected++;

    if (pix.last) begin
      scan_busy = 1'b0;
    end else if (scan_x >= box_hi_x) begin
      scan_x = box_lo_x;
      scan_y = scan_y + 1'b1;
    end else begin
      scan_x = scan_x + 1'b1;
    end
  endtask

  function automatic void check_field(input string name, input logic [COLOUR_W-1:0] want,
                                      input logic [COLOUR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // One process sees every edge: register writes, accepted requests and accepted
  // pixels are handled in a fixed order, so nothing hinges on scheduling.
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      for (int v = 0; v < 3; v++) begin
        tri_x[v] = '0;
        tri_y[v] = '0;
      end
      fill_value = '0;
      scan_x     = '0;
      scan_y     = '0;
      box_lo_x   = '0;
      box_hi_x   = '0;
      box_hi_y   = '0;
      scan_busy  = 1'b0;
    end else begin
      if (in_valid && in_ready) rasterize_request(in_start_scan);

      if (cfg_we) begin
        case (cfg_index)
          CFG_V0X:    tri_x[0]   = cfg_data[VTX_W-1:0];
          CFG_V0Y:    tri_y[0]   = cfg_data[VTX_W-1:0];
          CFG_V1X:    tri_x[1]   = cfg_data[VTX_W-1:0];
          CFG_V1Y:    tri_y[1]   = cfg_data[VTX_W-1:0];
          CFG_V2X:    tri_x[2]   = cfg_data[VTX_W-1:0];
          CFG_V2Y:    tri_y[2]   = cfg_data[VTX_W-1:0];
          CFG_COLOUR: fill_value = cfg_data;
          default: ;  // unused index: ignored
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel at x=%0d y=%0d arrived with no pixel pending",
                 out_pixel_x, out_pixel_y);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.x, out_pixel_x);
          check_field("pixel_y", want.y, out_pixel_y);
          check_field("covered", want.covered, out_covered);
          check_field("pixel_colour", want.colour, out_pixel_colour);
          check_field("last_pixel", want.last, out_last_pixel);
          pixels_checked++;
          if (want.covered) pixels_inside++;
          if (want.last) box_ends++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a stall pattern of its own, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      sink_tick = sink_tick + 1'b1;
      case (sink_tick[8:7])
        2'd0:    out_ready <= 1'b1;                        // no stalls at all
        2'd1:    out_ready <= ($urandom_range(3) != 0);    // light random stalls
        2'd2:    out_ready <= (sink_tick[2:0] != 3'd2) && (sink_tick[2:0] != 3'd5);
        default: out_ready <= 1'($urandom);                // heavy random stalls
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Hold valid low while idling; scramble the idle payload so it is seen to be ignored
  task automatic idle_input(input int n);
    for (int k = 0; k < n; k++) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_start_scan <= 1'($urandom);
    end
  endtask

  // Offer one scan request and hold it until the transaction completes.
  // Valid stays high on return so back-to-back requests leave no idle gap.
  task automatic send_scan_request(input logic start);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(0, MAX_GAP);
        burst_left = $urandom_range(1, MAX_BURST);
        if (gap != 0) idle_input(gap);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_start_scan <= start;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Drop valid, let every pending pixel arrive, then let the pipeline settle
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Load all seven registers; junk in the upper half of vertex writes must be masked
  task automatic write_triangle(input int x0, input int y0, input int x1, input int y1,
                                input int x2, input int y2, input logic [COLOUR_W-1:0] colour);
    write_reg(CFG_V0X, {16'($urandom), 16'(x0)});
    write_reg(CFG_V0Y, {16'($urandom), 16'(y0)});
    write_reg(CFG_V1X, {16'($urandom), 16'(x1)});
    write_reg(CFG_V1Y, {16'($urandom), 16'(y1)});
    write_reg(CFG_V2X, {16'($urandom), 16'(x2)});
    write_reg(CFG_V2Y, {16'($urandom), 16'(y2)});
    write_reg(CFG_COLOUR, colour);
    triangles_set++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full scan of a small right triangle: origin, row wrap, last pixel, then an
  // advance while idle that must yield nothing
  task automatic test_small_scan();
    wait_for_idle();
    write_triangle(1, 1, 3, 1, 1, 3, 32'hFFFF_FFFF);
    send_scan_request(1'b1);
    repeat (8) send_scan_request(1'b0);
    send_scan_request(1'b0);
  endtask

  // Vertices at the positive extreme: box clipped to the image's far corner,
  // so the last pixel sits at the top coordinate on both axes
  task automatic test_far_corner_clip();
    wait_for_idle();
    write_triangle(1022, 1022, 32767, 1022, 1022, 32767, 32'h8000_0001);
    send_scan_request(1'b1);
    repeat (3) send_scan_request(1'b0);
  endtask

  // Vertices at the negative extreme: box clipped to the origin; restart mid-scan
  task automatic test_origin_clip_restart();
    wait_for_idle();
    write_triangle(-32768, -32768, 1, -32768, -32768, 1, 32'h0000_0000);
    send_scan_request(1'b1);
    send_scan_request(1'b0);
    send_scan_request(1'b1);
    repeat (3) send_scan_request(1'b0);
  endtask

  // Empty box leaves the block idle; unused register index is ignored;
  // a zero-area triangle covers none of its pixels
  task automatic test_empty_and_degenerate();
    wait_for_idle();
    write_triangle(1024, 0, 32767, 5, 2000, 3, 32'h1234_5678);
    send_scan_request(1'b1);
    send_scan_request(1'b0);
    wait_for_idle();
    write_triangle(0, 0, 2, 2, 1, 1, $urandom);
    write_reg(CFG_UNUSED, $urandom);
    send_scan_request(1'b1);
    repeat (2) send_scan_request(1'b0);
  endtask

  // Hold the receiver off for a long stretch while requests keep coming:
  // the queue and pipeline fill and in_ready must drop, then recover
  task automatic test_backpressure_fill();
    wait_for_idle();
    write_triangle(0, 0, 9, 0, 0, 9, 32'hA5A5_5A5A);
    @(posedge clk);
    hold_requests++;
    send_scan_request(1'b1);
    repeat (39) send_scan_request(1'b0);
  endtask

  // Random triangles: mostly small ones scanned to completion, with partial
  // scans, restarts, overruns into idle, continued scans, empty and huge boxes
  task automatic test_random_triangles();
    int vx [3];
    int vy [3];
    int ox, oy, dx, dy, kind, mode, n, target;
    longint lo_x, hi_x, lo_y, hi_y, pixels;
    bit keep_scan;
    wait_for_idle();
    gaps_on = 1'b1;
    target  = pixels_expected + RANDOM_PIXELS;
    do begin
      kind = $urandom_range(9);
      ox   = int'($urandom_range(0, IMAGE_WIDTH + 16)) - 8;
      oy   = int'($urandom_range(0, IMAGE_HEIGHT + 16)) - 8;
      for (int v = 0; v < 3; v++) begin
        case (kind)
          5: begin  // thin sliver along a row
            vx[v] = ox + int'($urandom_range(0, 20));
            vy[v] = oy + int'($urandom_range(0, 2));
          end
          6: begin  // anywhere in the vertex range
            vx[v] = $signed(16'($urandom));
            vy[v] = $signed(16'($urandom));
          end
          8: begin  // wholly off the image
            vx[v] = -int'($urandom_range(1, 32768));
            vy[v] = IMAGE_HEIGHT + int'($urandom_range(0, 31743));
          end
          9: begin  // mix of range extremes and nearby points
            vx[v] = ($urandom_range(2) == 0) ? -32768 :
                    ($urandom_range(1) == 0) ? 32767 : ox + int'($urandom_range(0, 6));
            vy[v] = ($urandom_range(2) == 0) ? -32768 :
                    ($urandom_range(1) == 0) ? 32767 : oy + int'($urandom_range(0, 6));
          end
          default: begin
            vx[v] = ox + int'($urandom_range(0, 6));
            vy[v] = oy + int'($urandom_range(0, 6));
          end
        endcase
      end
      if (kind == 7) begin  // collinear, zero area
        dx = int'($urandom_range(0, 6)) - 3;
        dy = int'($urandom_range(0, 6)) - 3;
        vx[1] = vx[0] + dx;
        vy[1] = vy[0] + dy;
        vx[2] = vx[0] + 2 * dx;
        vy[2] = vy[0] + 2 * dy;
      end
      write_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], $urandom);

      // size of the clipped box, to pick how far to scan
      lo_x = vx[0]; hi_x = vx[0]; lo_y = vy[0]; hi_y = vy[0];
      for (int v = 1; v < 3; v++) begin
        if (vx[v] < lo_x) lo_x = vx[v];
        if (vx[v] > hi_x) hi_x = vx[v];
        if (vy[v] < lo_y) lo_y = vy[v];
        if (vy[v] > hi_y) hi_y = vy[v];
      end
      if (lo_x < 0) lo_x = 0;
      if (lo_y < 0) lo_y = 0;
      if (hi_x > IMAGE_WIDTH - 1) hi_x = IMAGE_WIDTH - 1;
      if (hi_y > IMAGE_HEIGHT - 1) hi_y = IMAGE_HEIGHT - 1;
      pixels = (lo_x > hi_x || lo_y > hi_y) ? 0 : (hi_x - lo_x + 1) * (hi_y - lo_y + 1);

      mode = $urandom_range(9);
      if (pixels == 0)       n = $urandom_range(0, 2);
      else if (pixels > 64)  n = $urandom_range(0, 30);
      else if (mode < 6)     n = int'(pixels) - 1;
      else if (mode < 8)     n = $urandom_range(0, int'(pixels) - 1);
      else                   n = int'(pixels) - 1 + $urandom_range(1, 3);

      // now and then skip the start and carry on with whatever scan was running
      keep_scan = ($urandom_range(11) == 0);
      if (keep_scan) n = $urandom_range(1, 8);
      else send_scan_request(1'b1);
      repeat (n) send_scan_request(1'b0);
      wait_for_idle();
    end while (pixels_expected < target);
    gaps_on = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_small_scan();
    test_far_corner_clip();
    test_origin_clip_restart();
    test_empty_and_degenerate();
    test_backpressure_fill();
    test_random_triangles();

    wait_for_idle();
    if (expected_pixels.size() != 0) begin
      $error("%0d pixels never arrived", expected_pixels.size());
      mismatches += expected_pixels.size();
    end
    $display("Scanned %0d triangle setups with %0d requests; %0d pixels checked,",
             triangles_set, requests_sent, pixels_checked);
    $display("%0d of them inside, %0d box ends, %0d mismatches.",
             pixels_inside, box_ends, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
